[hdl/two_wire_handshake_link_byte_engine_defines.svh]
// ----------------------------------------------------------------------------
// Two-wire link byte engine: assertion macros
// Shared property forms for the checker, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_WIRE_HANDSHAKE_LINK_BYTE_ENGINE_DEFINES_SVH
`define TWO_WIRE_HANDSHAKE_LINK_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define TWL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("two-wire link engine: same-cycle property failed");

// Next-cycle implication.
`define TWL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("two-wire link engine: next-cycle property failed");

`endif

[hdl/twl_pkg.sv]
// ----------------------------------------------------------------------------
// Two-wire link byte engine: package
// Beat payload types, register map and reset values shared by the project.
// ----------------------------------------------------------------------------
package twl_pkg;

  localparam int unsigned TimerWidthDefault = 32;
  localparam int unsigned TimeoutWidth      = 32;
  localparam int unsigned DebounceWidth     = 8;
  localparam int unsigned PaddrWidth        = 3;

  localparam logic [TimeoutWidth-1:0]  TimeoutReset  = 32'd1000000;
  localparam logic [DebounceWidth-1:0] DebounceReset = 8'd10;

  // Register select is address bit 2.
  localparam logic RegTimeout  = 1'b0;
  localparam logic RegDebounce = 1'b1;

  // Line patterns are {ring, tip}.
  localparam logic [1:0] PatIdle   = 2'b11;
  localparam logic [1:0] PatTipLow = 2'b10;

  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeSend = 2'd1;
  localparam logic [1:0] ModeRecv = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       tip_level;
    logic       ring_level;
  } twl_in_t;

  typedef struct packed {
    logic       tip_pull_low;
    logic       ring_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic [7:0] rx_byte;
  } twl_out_t;

endpackage

[hdl/two_wire_handshake_link_byte_engine.sv]
// ----------------------------------------------------------------------------
// Two-wire link byte engine
// Open-drain tip/ring handshake engine that sends or receives one byte LSB first.
// ----------------------------------------------------------------------------
// Each input beat is one time tick: the sampled tip and ring levels plus an
// optional command to start sending or receiving a byte. Every accepted beat
// produces exactly one output beat carrying the pull-low drives, busy, done,
// status and the received byte as they stand after that tick.
// The engine takes one beat per clock cycle while the input is not stalled. The
// output beat is registered: the result is computed from the state and the input
// beat and captured in the output register, or in the skid buffer on a stall.
// The output register is backed by a one-entry skid buffer, so a beat is still
// accepted in the cycle the receiver first stalls; the input stalls only while
// the skid buffer holds a beat.
// Timeout and debounce limits are written through the APB port at byte
// addresses 0 and 4, by the user only while the engine is idle (not enforced).
// Reset releases both lines, returns the engine to idle, empties the output
// side and restores the register reset values.
// ----------------------------------------------------------------------------
module two_wire_handshake_link_byte_engine
  import twl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  twl_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output twl_out_t                out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrWidth-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned CmpWidth =
    (TIMER_WIDTH > TimeoutWidth) ? TIMER_WIDTH : TimeoutWidth;

  typedef enum logic [2:0] {
    PhIdle,
    PhTxFree,
    PhTxAck,
    PhTxRel,
    PhRxStart,
    PhRxRel
  } phase_e;

  logic [TimeoutWidth-1:0]  timeout_q;
  logic [DebounceWidth-1:0] debounce_q;

  phase_e                   phase_q, phase_d;
  logic                     receiving_q, receiving_d;
  logic [2:0]               bit_index_q, bit_index_d;
  logic [7:0]               shift_q, shift_d;
  logic                     cur_bit_q, cur_bit_d;
  logic [TIMER_WIDTH-1:0]   timer_q, timer_d;
  logic [7:0]               deb_cnt_q, deb_cnt_d;
  logic [1:0]               pattern_q, pattern_d;

  twl_out_t                 out_q, skid_q, result;
  logic                     out_valid_q, skid_valid_q;

  logic                     in_acc, cfg_wr;
  logic [1:0]               pat;
  logic [TIMER_WIDTH-1:0]   timer_inc;
  logic                     expired, expired_rx, timeout, bit_done;
  logic                     line_sel;
  logic [7:0]               deb_next;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite;
  assign prdata     = (paddr[2] == RegDebounce) ? {24'd0, debounce_q} : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TimeoutReset;
      debounce_q <= DebounceReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegTimeout:  timeout_q  <= pwdata;
        RegDebounce: debounce_q <= pwdata[DebounceWidth-1:0];
        default:     timeout_q  <= timeout_q;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign pat        = {in_data_i.ring_level, in_data_i.tip_level};

  assign timer_inc  = (timer_q == {TIMER_WIDTH{1'b1}}) ? timer_q : timer_q + 1'b1;
  assign expired    = CmpWidth'(timer_inc) > CmpWidth'(timeout_q);
  assign expired_rx = (timeout_q != '0) & expired;

  always_comb begin
    phase_d     = phase_q;
    receiving_d = receiving_q;
    bit_index_d = bit_index_q;
    shift_d     = shift_q;
    cur_bit_d   = cur_bit_q;
    timer_d     = timer_q;
    deb_cnt_d   = deb_cnt_q;
    pattern_d   = pattern_q;
    timeout     = 1'b0;
    bit_done    = 1'b0;
    deb_next    = deb_cnt_q;
    line_sel    = cur_bit_q ? in_data_i.tip_level : in_data_i.ring_level;
    result      = '0;

    unique case (phase_q)
      PhIdle: begin
        if (in_data_i.mode == ModeSend || in_data_i.mode == ModeRecv) begin
          receiving_d = (in_data_i.mode == ModeRecv);
          shift_d     = receiving_d ? 8'd0 : in_data_i.tx_byte;
          cur_bit_d   = receiving_d ? 1'b0 : in_data_i.tx_byte[0];
          bit_index_d = '0;
          timer_d     = '0;
          deb_cnt_d   = '0;
          pattern_d   = PatIdle;
          phase_d     = receiving_d ? PhRxStart : PhTxFree;
        end
      end
      PhTxFree: begin
        if (pat == PatIdle) begin
          phase_d = PhTxAck;
          timer_d = '0;
        end else begin
          timer_d = timer_inc;
          timeout = expired;
        end
      end
      PhTxAck: begin
        if (!line_sel) begin
          phase_d = PhTxRel;
          timer_d = '0;
        end else begin
          timer_d = timer_inc;
          timeout = expired;
        end
      end
      PhTxRel: begin
        if (line_sel) begin
          shift_d  = {1'b0, shift_q[7:1]};
          bit_done = 1'b1;
        end else begin
          timer_d = timer_inc;
          timeout = expired;
        end
      end
      PhRxStart: begin
        if (pat == PatIdle) begin
          deb_cnt_d = '0;
          pattern_d = PatIdle;
          timer_d   = timer_inc;
          timeout   = expired_rx;
        end else begin
          if (pattern_q == PatIdle) begin
            deb_next = '0;
          end else if (deb_cnt_q != 8'hFF) begin
            deb_next = deb_cnt_q + 1'b1;
          end
          deb_cnt_d = deb_next;
          pattern_d = pat;
          if (deb_next >= debounce_q) begin
            cur_bit_d = (pat != PatTipLow);
            phase_d   = PhRxRel;
            timer_d   = '0;
          end else begin
            timer_d = timer_inc;
            timeout = expired_rx;
          end
        end
      end
      PhRxRel: begin
        if (cur_bit_q ? in_data_i.ring_level : in_data_i.tip_level) begin
          shift_d  = {cur_bit_q, shift_q[7:1]};
          bit_done = 1'b1;
        end else begin
          timer_d = timer_inc;
          timeout = expired_rx;
        end
      end
      default: phase_d = PhIdle;
    endcase

    if (timeout) begin
      phase_d         = PhIdle;
      result.done_res = 1'b1;
      result.status   = 1'b1;
    end else if (bit_done) begin
      if (bit_index_q == 3'd7) begin
        phase_d         = PhIdle;
        result.done_res = 1'b1;
        result.rx_byte  = receiving_q ? shift_d : 8'd0;
        bit_index_d     = '0;
      end else begin
        bit_index_d = bit_index_q + 1'b1;
        timer_d     = '0;
        if (receiving_q) begin
          deb_cnt_d = '0;
          pattern_d = PatIdle;
          phase_d   = PhRxStart;
        end else begin
          cur_bit_d = shift_d[0];
          phase_d   = PhTxFree;
        end
      end
    end

    result.tip_pull_low  = (phase_d == PhTxAck && !cur_bit_d) ||
                           (phase_d == PhRxRel && cur_bit_d);
    result.ring_pull_low = (phase_d == PhTxAck && cur_bit_d) ||
                           (phase_d == PhRxRel && !cur_bit_d);
    result.busy_res      = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      receiving_q <= 1'b0;
      bit_index_q <= '0;
      shift_q     <= '0;
      cur_bit_q   <= 1'b0;
      timer_q     <= '0;
      deb_cnt_q   <= '0;
      pattern_q   <= PatIdle;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      receiving_q <= receiving_d;
      bit_index_q <= bit_index_d;
      shift_q     <= shift_d;
      cur_bit_q   <= cur_bit_d;
      timer_q     <= timer_d;
      deb_cnt_q   <= deb_cnt_d;
      pattern_q   <= pattern_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (in_acc) begin
        skid_q <= result;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/twl_checker.sv]
// ----------------------------------------------------------------------------
// Two-wire link byte engine: port checker
// Watches the engine's output beats and is bound to the engine module.
// ----------------------------------------------------------------------------
`include "two_wire_handshake_link_byte_engine_defines.svh"

module twl_checker
  import twl_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input twl_out_t out_data_o
);

  logic any_pull, both_pull, rx_nonzero, side_info, rx_on_fail;

  assign any_pull   = out_data_o.tip_pull_low | out_data_o.ring_pull_low;
  assign both_pull  = out_data_o.tip_pull_low & out_data_o.ring_pull_low;
  assign rx_nonzero = (out_data_o.rx_byte != 8'd0);
  assign side_info  = out_data_o.status | rx_nonzero;
  assign rx_on_fail = out_data_o.status & rx_nonzero;

  // A stalled output beat holds.
  `TWL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Only one line is ever driven low at a time.
  `TWL_ASSERT_NOW(a_one_pull, out_valid_o, !both_pull)

  // A line is only driven while a transfer is in progress.
  `TWL_ASSERT_NOW(a_pull_busy, out_valid_o && any_pull, out_data_o.busy_res)

  // A finished or aborted transfer leaves the engine idle.
  `TWL_ASSERT_NOW(a_done_idle, out_valid_o && out_data_o.done_res, !out_data_o.busy_res)

  // Status and received data only appear with done, and data only on success.
  `TWL_ASSERT_NOW(a_rx_status, out_valid_o && side_info, out_data_o.done_res && !rx_on_fail)

endmodule

bind two_wire_handshake_link_byte_engine twl_checker u_twl_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-wire link byte engine: testbench
// A hand-written table of ticks is run first. It covers timeouts, starts that
// are ignored while busy, the spare mode and the field extremes. Random ticks
// follow under six register settings. A reactive peer answers the engine's
// pulls, with random lag and line glitches, so that whole bytes go both ways.
// Every result beat is compared field by field with a cycle-level predictor,
// or with the table's value for fixed rows. Both channels idle and stall at
// random, and there is one long stall on the result side.
// ----------------------------------------------------------------------------
module tb;
  import twl_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;

  localparam logic [PaddrWidth-1:0] AddrTimeout  = {RegTimeout, 2'b00};
  localparam logic [PaddrWidth-1:0] AddrDebounce = {RegDebounce, 2'b00};

  localparam int WatchdogLimit = 1000;
  localparam int LongHold      = 64;
  localparam int NumPhases     = 6;

  localparam logic [31:0] PhaseTimeout [NumPhases] =
    '{32'd20, 32'd0, 32'hFFFF_FFFF, 32'd4, TimeoutReset, 32'd7};
  localparam logic [7:0] PhaseDebounce [NumPhases] =
    '{8'd3, 8'd0, 8'd2, 8'd1, DebounceReset, 8'd255};
  localparam int PhaseBeats [NumPhases] = '{130, 130, 250, 130, 100, 110};

  localparam twl_out_t ResQuiet = '0;
  localparam twl_out_t ResLoaded = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam twl_out_t ResTimedOut = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00};

  typedef struct packed {
    logic                  wr;
    logic [PaddrWidth-1:0] addr;
    logic [31:0]           wdata;
    twl_in_t               beat;
    logic                  fixed;
    twl_out_t              res;
  } plan_row_t;

  localparam int DirRows = 19;
  localparam plan_row_t DirPlan [DirRows] = '{
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b1}, 1'b1, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeSpare, 8'hFF, 1'b0, 1'b0}, 1'b1, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'hFF, 1'b0, 1'b1}, 1'b1, ResQuiet},
    '{1'b1, AddrTimeout,  32'd2, '0, 1'b0, ResQuiet},
    '{1'b1, AddrDebounce, 32'd0, '0, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeSend,  8'hFF, 1'b1, 1'b1}, 1'b1, ResLoaded},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b0, 1'b0}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeRecv,  8'h00, 1'b0, 1'b1}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b0}, 1'b1, ResTimedOut},
    '{1'b0, AddrTimeout,  32'd0, '{ModeRecv,  8'h00, 1'b1, 1'b1}, 1'b1, ResLoaded},
    '{1'b0, AddrTimeout,  32'd0, '{ModeSend,  8'hFF, 1'b0, 1'b1}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b0}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b1}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeSpare, 8'h00, 1'b1, 1'b1}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b1}, 1'b1, ResTimedOut},
    '{1'b1, AddrTimeout,  32'd0, '0, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeSend,  8'h00, 1'b1, 1'b1}, 1'b1, ResLoaded},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b1}, 1'b0, ResQuiet},
    '{1'b0, AddrTimeout,  32'd0, '{ModeTick,  8'h00, 1'b1, 1'b1}, 1'b1, ResTimedOut}
  };

  typedef enum logic [2:0] {
    StIdle, StTxFree, StTxAck, StTxRel, StRxStart, StRxRel
  } link_state_e;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  twl_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  twl_out_t              out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PaddrWidth-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  two_wire_handshake_link_byte_engine i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  logic [31:0]                 tmo_limit;
  logic [7:0]                  deb_limit;
  link_state_e                 st;
  logic                        rx_mode;
  logic [2:0]                  bit_no;
  logic [7:0]                  shreg;
  logic                        cur_bit;
  logic [TimerWidthDefault-1:0] tmr;
  logic [7:0]                  run_len;
  logic [1:0]                  seen;

  logic     peer_tip;
  logic     peer_ring;
  int       peer_lag;
  logic [7:0] peer_byte;
  logic [7:0] peer_both;

  twl_out_t link_expected [$];
  int       mismatches = 0;
  int       beats_seen = 0;
  int       quiet = 0;
  int       holds_asked = 0;
  int       holds_served = 0;
  int       hold_left = 0;
  int       burst_left = 0;
  bit       calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic link_reset();
    tmo_limit = TimeoutReset;
    deb_limit = DebounceReset;
    st        = StIdle;
    rx_mode   = 1'b0;
    bit_no    = '0;
    shreg     = '0;
    cur_bit   = 1'b0;
    tmr       = '0;
    run_len   = '0;
    seen      = PatIdle;
  endtask

  function automatic logic wait_lapsed(input logic forever_if_zero);
    if (tmr != '1) tmr++;
    if (forever_if_zero && tmo_limit == '0) return 1'b0;
    return tmr > tmo_limit;
  endfunction

  function automatic twl_out_t link_tick(input twl_in_t b);
    twl_out_t   r;
    logic [1:0] pat;
    logic       lapsed;
    logic       bit_end;
    logic       accept;
    pat     = {b.ring_level, b.tip_level};
    lapsed  = 1'b0;
    bit_end = 1'b0;
    accept  = 1'b0;
    r       = '0;
    case (st)
      StIdle: begin
        if (b.mode == ModeSend || b.mode == ModeRecv) begin
          rx_mode = (b.mode == ModeRecv);
          shreg   = rx_mode ? 8'h00 : b.tx_byte;
          cur_bit = rx_mode ? 1'b0 : b.tx_byte[0];
          bit_no  = '0;
          tmr     = '0;
          run_len = '0;
          seen    = PatIdle;
          st      = rx_mode ? StRxStart : StTxFree;
        end
      end
      StTxFree: begin
        if (pat == PatIdle) begin
          st  = StTxAck;
          tmr = '0;
        end else begin
          lapsed = wait_lapsed(1'b0);
        end
      end
      StTxAck: begin
        if (!(cur_bit ? b.tip_level : b.ring_level)) begin
          st  = StTxRel;
          tmr = '0;
        end else begin
          lapsed = wait_lapsed(1'b0);
        end
      end
      StTxRel: begin
        if (cur_bit ? b.tip_level : b.ring_level) begin
          shreg   = shreg >> 1;
          bit_end = 1'b1;
        end else begin
          lapsed = wait_lapsed(1'b0);
        end
      end
      StRxStart: begin
        if (pat == PatIdle) begin
          run_len = '0;
          seen    = PatIdle;
        end else begin
          if (seen == PatIdle) run_len = '0;
          else if (run_len != 8'hFF) run_len++;
          seen   = pat;
          accept = (run_len >= deb_limit);
        end
        if (accept) begin
          cur_bit = (seen != PatTipLow);
          st      = StRxRel;
          tmr     = '0;
        end else begin
          lapsed = wait_lapsed(1'b1);
        end
      end
      StRxRel: begin
        if (cur_bit ? b.ring_level : b.tip_level) begin
          shreg   = {cur_bit, shreg[7:1]};
          bit_end = 1'b1;
        end else begin
          lapsed = wait_lapsed(1'b1);
        end
      end
      default: st = StIdle;
    endcase

    if (lapsed) begin
      st         = StIdle;
      r.done_res = 1'b1;
      r.status   = 1'b1;
    end else if (bit_end) begin
      if (bit_no == 3'd7) begin
        st         = StIdle;
        r.done_res = 1'b1;
        if (rx_mode) r.rx_byte = shreg;
        bit_no     = '0;
      end else begin
        bit_no++;
        tmr = '0;
        if (rx_mode) begin
          run_len = '0;
          seen    = PatIdle;
          st      = StRxStart;
        end else begin
          cur_bit = shreg[0];
          st      = StTxFree;
        end
      end
    end

    r.tip_pull_low  = (st == StTxAck && !cur_bit) || (st == StRxRel && cur_bit);
    r.ring_pull_low = (st == StTxAck && cur_bit) || (st == StRxRel && !cur_bit);
    r.busy_res      = (st != StIdle);
    return r;
  endfunction

  // The peer answers the engine's pulls after a random lag; the line levels
  // are the wired AND of both sides, with the odd glitch on top.
  function automatic twl_in_t next_tick_beat();
    twl_in_t     b;
    logic        want_tip;
    logic        want_ring;
    logic        eng_tip;
    logic        eng_ring;
    int unsigned pick;
    b.tx_byte = 8'($urandom);
    pick      = $urandom_range(15);
    if (st == StIdle) begin
      if (pick < 6) begin
        b.mode = ModeSend;
      end else if (pick < 12) begin
        b.mode    = ModeRecv;
        peer_byte = 8'($urandom);
        peer_both = 8'($urandom);
      end else if (pick < 14) begin
        b.mode = ModeTick;
      end else begin
        b.mode = ModeSpare;
      end
    end else begin
      case (pick)
        12:      b.mode = ModeSend;
        13:      b.mode = ModeRecv;
        14:      b.mode = ModeSpare;
        default: b.mode = ModeTick;
      endcase
    end

    want_tip  = 1'b0;
    want_ring = 1'b0;
    eng_tip   = 1'b0;
    eng_ring  = 1'b0;
    case (st)
      StTxAck: begin
        if (cur_bit) begin
          want_tip = 1'b1;
          eng_ring = 1'b1;
        end else begin
          want_ring = 1'b1;
          eng_tip   = 1'b1;
        end
      end
      StRxStart: begin
        want_ring = peer_byte[bit_no];
        want_tip  = !peer_byte[bit_no] || peer_both[bit_no];
      end
      StRxRel: begin
        if (cur_bit) eng_tip = 1'b1;
        else eng_ring = 1'b1;
      end
      default: ;
    endcase

    if ({want_tip, want_ring} != {peer_tip, peer_ring}) begin
      if (peer_lag == 0) begin
        peer_tip  = want_tip;
        peer_ring = want_ring;
        peer_lag  = ($urandom_range(19) == 0) ? $urandom_range(30) : $urandom_range(2);
      end else begin
        peer_lag--;
      end
    end
    b.tip_level  = !(peer_tip || eng_tip);
    b.ring_level = !(peer_ring || eng_ring);
    if ($urandom_range(63) == 0) {b.ring_level, b.tip_level} = 2'($urandom);
    return b;
  endfunction

  task automatic offer_beat(input twl_in_t b, input logic fixed, input twl_out_t res,
                            input int gap);
    twl_out_t pred;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    pred = link_tick(b);
    link_expected.push_back(fixed ? res : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (link_expected.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [PaddrWidth-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (a == AddrTimeout) tmo_limit = d;
    else deb_limit = d[7:0];
    @(posedge clk_i);
  endtask

  task automatic reg_check(input logic [PaddrWidth-1:0] a, input logic [31:0] want);
    logic [31:0] mask;
    mask    = (a == AddrDebounce) ? 32'h0000_00FF : 32'hFFFF_FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (want & mask)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: register at %0h reads %0h, expected %0h",
                 a, prdata & mask, want & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: %s on result beat %0d: expected %0h, got %0h",
                 name, beats_seen, want, got);
    end
  endtask

  initial begin : stimulus
    int gap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    link_reset();
    @(posedge clk_i);
    reg_check(AddrTimeout, TimeoutReset);
    reg_check(AddrDebounce, 32'(DebounceReset));

    foreach (DirPlan[i]) begin
      if (DirPlan[i].wr) begin
        drain();
        reg_write(DirPlan[i].addr, DirPlan[i].wdata);
      end else begin
        gap = ($urandom_range(4) == 0) ? $urandom_range(1, 8) : 0;
        offer_beat(DirPlan[i].beat, DirPlan[i].fixed, DirPlan[i].res, gap);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      reg_write(AddrTimeout, PhaseTimeout[p]);
      reg_write(AddrDebounce, 32'(PhaseDebounce[p]));
      reg_check(AddrTimeout, PhaseTimeout[p]);
      reg_check(AddrDebounce, 32'(PhaseDebounce[p]));
      calm      = (p == NumPhases - 1);
      peer_tip  = 1'b0;
      peer_ring = 1'b0;
      peer_lag  = 0;
      peer_byte = '0;
      peer_both = '0;
      for (int n = 0; n < PhaseBeats[p]; n++) begin
        if (p == 0 && n == 20) holds_asked++;
        if (calm || (p == 0 && n >= 20 && n < 100) || $urandom_range(4) != 0) gap = 0;
        else gap = $urandom_range(1, 8);
        offer_beat(next_tick_beat(), 1'b0, ResQuiet, gap);
      end
      while (st != StIdle) offer_beat(next_tick_beat(), 1'b0, ResQuiet, 0);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin : result_side
    twl_out_t want;
    logic     hold_next;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (link_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result beat %0d arrived unexpected", beats_seen);
      end else begin
        want = link_expected.pop_front();
        check_field("tip_pull_low", 8'(want.tip_pull_low), 8'(out_data_o.tip_pull_low));
        check_field("ring_pull_low", 8'(want.ring_pull_low), 8'(out_data_o.ring_pull_low));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data_o.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data_o.done_res));
        check_field("status", 8'(want.status), 8'(out_data_o.status));
        check_field("rx_byte", want.rx_byte, out_data_o.rx_byte);
      end
    end

    if (hold_left > 0) begin
      hold_left--;
      hold_next = 1'b1;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = LongHold - 1;
      hold_next = 1'b1;
    end else if (calm) begin
      hold_next = 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      hold_next = 1'b1;
    end else if ($urandom_range(7) == 0) begin
      burst_left = $urandom_range(7);
      hold_next  = 1'b1;
    end else begin
      hold_next = 1'b0;
    end
    out_stall_i <= hold_next;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/twl_pkg.sv
hdl/two_wire_handshake_link_byte_engine.sv
hdl/twl_checker.sv
verif/tb.sv
